[src/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg
// shared constants, codes and types of the cpu bus decoder with sprite dma
// ----------------------------------------------------------------------------
package cbd_pkg;

  // default sizes
  localparam int RAM_BYTES_DEF    = 2048;
  localparam int SPRITE_BYTES_DEF = 256;
  localparam int PAGE_SHIFT       = 8;   // source page is 256 bytes

  // item kinds
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // decode targets
  localparam logic [2:0] TGT_CART = 3'd0;
  localparam logic [2:0] TGT_RAM  = 3'd1;
  localparam logic [2:0] TGT_PIC  = 3'd2;
  localparam logic [2:0] TGT_DMA  = 3'd3;
  localparam logic [2:0] TGT_PAD1 = 3'd4;
  localparam logic [2:0] TGT_PAD2 = 3'd5;
  localparam logic [2:0] TGT_SND  = 3'd6;
  localparam logic [2:0] TGT_NONE = 3'd7;

  // dma phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SCHED = 2'd1;
  localparam logic [1:0] PH_DUMMY = 2'd2;
  localparam logic [1:0] PH_XFER  = 2'd3;

  // address map
  localparam logic [15:0] ADDR_RAM_END  = 16'h1FFF;
  localparam logic [15:0] ADDR_PIC_END  = 16'h3FFF;
  localparam logic [15:0] ADDR_SND_END  = 16'h4013;
  localparam logic [15:0] ADDR_TRIG     = 16'h4014;
  localparam logic [15:0] ADDR_SND_STAT = 16'h4015;
  localparam logic [15:0] ADDR_PAD1     = 16'h4016;
  localparam logic [15:0] ADDR_PAD2     = 16'h4017;

  typedef struct packed {
    logic [2:0] target;
    logic [4:0] reg_index;
    logic       ram_hit;
    logic       rd_cart;
    logic       rd_periph;
    logic       trig;
  } dec_t;

  typedef struct packed {
    logic       cpu_enable;
    logic       sprite_write;
    logic [7:0] sprite_addr;
    logic       latch_ld;
    logic       busy;
  } dma_ctl_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] target;
    logic [4:0] reg_index;
    logic       cpu_enable;
    logic       sprite_write;
    logic [7:0] sprite_addr;
    logic [7:0] sprite_data;
    logic       dma_busy;
  } res_t;

endpackage

[src/cbd_decode.sv]
// ----------------------------------------------------------------------------
// cbd_decode
// priority address decode of one cpu read or write
// ----------------------------------------------------------------------------
module cbd_decode (
  input  logic [1:0]    action,
  input  logic [15:0]   address,
  input  logic          cart_claims,
  output cbd_pkg::dec_t dec
);
  import cbd_pkg::*;

  logic is_rd;
  logic is_wr;

  assign is_rd = (action == ACT_READ);
  assign is_wr = (action == ACT_WRITE);

  always_comb begin
    dec = '0;
    dec.target = TGT_NONE;
    if (is_rd || is_wr) begin
      priority if (cart_claims) begin
        dec.target  = TGT_CART;
        dec.rd_cart = 1'b1;
      end else if (address <= ADDR_RAM_END) begin
        dec.target  = TGT_RAM;
        dec.ram_hit = 1'b1;
      end else if (address <= ADDR_PIC_END) begin
        dec.target    = TGT_PIC;
        dec.reg_index = {2'b00, address[2:0]};
        dec.rd_periph = 1'b1;
      end else if (is_wr && address == ADDR_TRIG) begin
        dec.target = TGT_DMA;
        dec.trig   = 1'b1;
      end else if (address == ADDR_PAD1) begin
        dec.target    = TGT_PAD1;
        dec.rd_periph = 1'b1;
      end else if (address == ADDR_PAD2) begin
        dec.target    = TGT_PAD2;
        dec.rd_periph = 1'b1;
      end else if (address <= ADDR_SND_END || address == ADDR_SND_STAT) begin
        // only the status register answers reads
        dec.target    = TGT_SND;
        dec.reg_index = address[4:0];
        dec.rd_periph = (address == ADDR_SND_STAT);
      end else begin
        dec.target = TGT_NONE;
      end
    end
  end

endmodule

[src/cbd_ram.sv]
// ----------------------------------------------------------------------------
// cbd_ram
// work ram: one write and one registered read port, zero fill after reset
// ----------------------------------------------------------------------------
module cbd_ram #(
  parameter int DEPTH = cbd_pkg::RAM_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata,
  output logic                     clr_busy
);
  import cbd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // clearing pass, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= 8'h00;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

[src/cbd_dma.sv]
// ----------------------------------------------------------------------------
// cbd_dma
// sprite copy sequencer: phase, source, destination and cycle parity
// ----------------------------------------------------------------------------
module cbd_dma #(
  parameter int RAM_BYTES    = cbd_pkg::RAM_BYTES_DEF,
  parameter int SPRITE_BYTES = cbd_pkg::SPRITE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick_go,
  input  logic                         trig_go,
  input  logic [7:0]                   page,
  output cbd_pkg::dma_ctl_t            ctl,
  output logic [$clog2(RAM_BYTES)-1:0] rd_addr
);
  import cbd_pkg::*;

  localparam int AW = $clog2(RAM_BYTES);

  logic [1:0]      phase_r, phase_nxt, phase_eff;
  logic [AW-1:0]   src_r, src_nxt;
  logic [8:0]      dest_r, dest_nxt, dest_inc;
  logic            odd_r, odd_nxt;
  logic [AW+7:0]   page_base;

  assign page_base = {{AW{1'b0}}, page} << PAGE_SHIFT;
  assign dest_inc  = dest_r + 9'd1;

  always_comb begin
    unique case (phase_r)
      PH_SCHED: phase_eff = odd_r ? PH_DUMMY : PH_XFER;
      PH_DUMMY: phase_eff = PH_XFER;
      default:  phase_eff = phase_r;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    src_nxt   = src_r;
    dest_nxt  = dest_r;
    odd_nxt   = odd_r;
    ctl       = '0;
    if (tick_go) begin
      odd_nxt        = ~odd_r;
      ctl.cpu_enable = (phase_r == PH_IDLE);
      phase_nxt      = phase_eff;
      if (phase_eff == PH_XFER) begin
        if (odd_r) begin
          ctl.sprite_write = 1'b1;
          ctl.sprite_addr  = dest_r[7:0];
          dest_nxt         = dest_inc;
          if (dest_inc >= 9'(SPRITE_BYTES)) begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          ctl.latch_ld = 1'b1;
          src_nxt      = src_r + 1'b1;
        end
      end
    end else if (trig_go) begin
      // a new trigger restarts the copy
      phase_nxt = PH_SCHED;
      src_nxt   = page_base[AW-1:0];
      dest_nxt  = '0;
    end
    ctl.busy = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      src_r   <= '0;
      dest_r  <= '0;
      odd_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      src_r   <= src_nxt;
      dest_r  <= dest_nxt;
      odd_r   <= odd_nxt;
    end
  end

  assign rd_addr = src_r;

endmodule

[src/cpu_bus_decode_with_sprite_dma.sv]
// ----------------------------------------------------------------------------
// cpu_bus_decode_with_sprite_dma
// cpu bus decode, work ram and sprite-memory copy engine
// ----------------------------------------------------------------------------
// pipeline: two register stages, stage 1 and the output register; out_tvalid
//   rises when a beat moves from stage 1 into the output register
// throughput: one beat per cycle unless the output stalls or the ram clears
// reset: synchronous, active low; afterwards the work ram is zero-filled one
//   byte a cycle, during which in_tready stays low
// config writes are always taken (cfg_ready is tied high)
// ----------------------------------------------------------------------------
module cpu_bus_decode_with_sprite_dma #(
  parameter int RAM_BYTES    = cbd_pkg::RAM_BYTES_DEF,
  parameter int SPRITE_BYTES = cbd_pkg::SPRITE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  // address[15:0], write_data[23:16], cart_claims[24], cart_data[32:25],
  // periph_data[40:33], zero pad [47:41]
  input  logic [47:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0], reg_index[12:8], cpu_enable[13], sprite_write[14],
  // sprite_addr[22:15], sprite_data[30:23], dma_busy[31]
  output logic [31:0] out_tdata,
  // target[2:0]
  output logic [2:0]  out_tuser,
  // open bus value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import cbd_pkg::*;

  localparam int AW = $clog2(RAM_BYTES);

  // input fields
  logic [1:0]  act;
  logic [15:0] addr;
  logic [7:0]  wr_data;
  logic        cart_claims;
  logic [7:0]  cart_data;
  logic [7:0]  periph_data;

  assign act         = in_tuser;
  assign addr        = in_tdata[15:0];
  assign wr_data     = in_tdata[23:16];
  assign cart_claims = in_tdata[24];
  assign cart_data   = in_tdata[32:25];
  assign periph_data = in_tdata[40:33];

  logic        in_acc;
  dec_t        dec;
  dma_ctl_t    dma_ctl;
  logic [AW-1:0] dma_rd_addr;
  logic        ram_busy;
  logic [7:0]  mem_q;
  logic        ram_we, ram_re, cpu_ram_rd;
  logic [AW-1:0] ram_raddr;

  // open bus register
  logic [7:0]  open_bus_r;

  // stage 1: waits for the ram read data
  logic        s1_v_r;
  res_t        s1_res_r, s0_res;
  logic        s1_ram_rd_r;
  logic        s1_latch_ld_r;
  logic        s1_adv;

  // byte carried from an even dma tick to the next odd one
  logic [7:0]  latch_r;

  // output register
  logic        out_v_r;
  res_t        out_res_r, s1_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_bus_r <= 8'h00;
    end else if (cfg_valid) begin
      open_bus_r <= cfg_data;
    end
  end

  // ------------------------------------------------------------------
  // stage 0: decode, dma step and ram access issue at the accept edge
  // ------------------------------------------------------------------
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !ram_busy && (!s1_v_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  cbd_decode u_dec (
    .action      (act),
    .address     (addr),
    .cart_claims (cart_claims),
    .dec         (dec)
  );

  cbd_dma #(
    .RAM_BYTES    (RAM_BYTES),
    .SPRITE_BYTES (SPRITE_BYTES)
  ) u_dma (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_go (in_acc && act == ACT_TICK),
    .trig_go (in_acc && dec.trig),
    .page    (wr_data),
    .ctl     (dma_ctl),
    .rd_addr (dma_rd_addr)
  );

  // cpu access and dma read never share one beat
  assign cpu_ram_rd = dec.ram_hit && (act == ACT_READ);
  assign ram_we     = in_acc && dec.ram_hit && (act == ACT_WRITE);
  assign ram_re     = in_acc && (cpu_ram_rd || dma_ctl.latch_ld);
  assign ram_raddr  = dma_ctl.latch_ld ? dma_rd_addr : addr[AW-1:0];

  cbd_ram #(
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (ram_we),
    .waddr    (addr[AW-1:0]),
    .wdata    (wr_data),
    .re       (ram_re),
    .raddr    (ram_raddr),
    .rdata    (mem_q),
    .clr_busy (ram_busy)
  );

  always_comb begin
    s0_res              = '0;
    s0_res.target       = dec.target;
    s0_res.reg_index    = dec.reg_index;
    s0_res.cpu_enable   = dma_ctl.cpu_enable;
    s0_res.sprite_write = dma_ctl.sprite_write;
    s0_res.sprite_addr  = dma_ctl.sprite_addr;
    s0_res.dma_busy     = dma_ctl.busy;
    // ram reads are filled in from the ram in stage 1
    if (act == ACT_READ) begin
      priority if (dec.rd_cart) begin
        s0_res.read_data = cart_data;
      end else if (dec.rd_periph) begin
        s0_res.read_data = periph_data;
      end else if (dec.ram_hit) begin
        s0_res.read_data = 8'h00;
      end else begin
        s0_res.read_data = open_bus_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r      <= s0_res;
      s1_ram_rd_r   <= cpu_ram_rd;
      s1_latch_ld_r <= dma_ctl.latch_ld;
    end
  end

  // ------------------------------------------------------------------
  // stage 1: merge ram data, carry the dma byte
  // ------------------------------------------------------------------
  always_comb begin
    s1_res = s1_res_r;
    if (s1_ram_rd_r) begin
      s1_res.read_data = mem_q;
    end
    if (s1_res_r.sprite_write) begin
      s1_res.sprite_data = latch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 8'h00;
    end else if (s1_adv && s1_latch_ld_r) begin
      latch_r <= mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= s1_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {out_res_r.dma_busy, out_res_r.sprite_data, out_res_r.sprite_addr,
                       out_res_r.sprite_write, out_res_r.cpu_enable, out_res_r.reg_index,
                       out_res_r.read_data};

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    ram_busy |-> !in_tready)
    else $error("beat taken during ram clearing pass");

  a_ram_data_held_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> $stable(mem_q))
    else $error("ram read data changed under a stalled beat");

  // the last sprite write of a copy already reports the copy as done
  a_sprite_write_stalls_cpu : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.sprite_write) |->
      (!out_res_r.cpu_enable && out_res_r.target == TGT_NONE))
    else $error("sprite write beat with cpu enabled or decoded target");

  a_trigger_sets_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec.trig) |=> (s1_v_r && s1_res_r.dma_busy && s1_res_r.target == TGT_DMA))
    else $error("trigger write did not schedule the copy");

  a_single_ram_access : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("ram read and write issued on one beat");

endmodule
